// File: hdl/clt_pkg.sv
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types, constants and helpers of the command line tokenizer.
// ----------------------------------------------------------------------------
package clt_pkg;

   localparam int MAX_ARGS    = 16;
   localparam int CNT_W       = $clog2(MAX_ARGS + 1);
   localparam int MAX_RESULTS = 4;
   localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
   localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CHAR_W      = 8;
   localparam int TOKEN_IDX_W = 4;
   localparam int ARG_COUNT_W = 5;

   localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
   localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_DONE = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_UNTERM   = 2'd1,
      STATUS_TOO_MANY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                 kind;
      logic [CHAR_W-1:0]        token_byte;
      logic [TOKEN_IDX_W-1:0]   token_index;
      status_type               line_status;
      logic [ARG_COUNT_W-1:0]   arg_count;
   } rsp_item_type;

   // all results caused by one accepted item
   typedef struct packed {
      logic [RES_CNT_W-1:0]               n;
      rsp_item_type [MAX_RESULTS-1:0]     item;
   } pkt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic rsp_item_type make_item(input kind_type        kind,
                                              input logic [CHAR_W-1:0] byte_v,
                                              input logic [CNT_W-1:0]  cnt,
                                              input status_type      status);
      rsp_item_type r;
      r.kind        = kind;
      r.token_byte  = byte_v;
      r.token_index = (kind == KIND_DONE) ? '0 : TOKEN_IDX_W'(cnt);
      r.line_status = status;
      r.arg_count   = (kind == KIND_DONE) ? ARG_COUNT_W'(cnt) : '0;
      return r;
   endfunction

endpackage

// File: hdl/clt_front.sv
// ----------------------------------------------------------------------------
// clt_front
// Accepts characters, tracks scan state and builds the result packet per item.
// ----------------------------------------------------------------------------
module clt_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic                         full,
   input  logic [clt_pkg::CHAR_W-1:0]   char_in,
   input  logic                         line_end,
   output logic                         q_push,
   output clt_pkg::pkt_type             q_pkt
);
   import clt_pkg::*;

   typedef enum logic [1:0] {
      MODE_GAP    = 2'd0,
      MODE_TOKEN  = 2'd1,
      MODE_QUOTED = 2'd2
   } mode_type;

   mode_type              mode_ff, mode_in;
   logic                  bsp_ff, bsp_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  err_ff, err_in;
   logic                  accept;
   pkt_type               pkt;

   assign accept = push && !full;

   always_comb begin
      logic                 ws;
      logic                 do_handle;
      logic                 go;
      logic [RES_CNT_W-1:0] slot;
      status_type           status;
      mode_in   = mode_ff;
      bsp_in    = bsp_ff;
      cnt_in    = cnt_ff;
      err_in    = err_ff;
      pkt       = '0;
      slot      = '0;
      status    = STATUS_OK;
      ws        = (char_in == CH_SPACE) || (char_in == CH_TAB);
      do_handle = 1'b0;
      go        = 1'b0;

      if (!err_ff) begin
         if (bsp_ff) begin
            bsp_in = 1'b0;
            if (char_in == CH_QUOTE) begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_BYTE, CH_QUOTE, cnt_in, STATUS_OK);
               slot = slot + 1'b1;
            end else begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_BYTE, CH_BSLASH, cnt_in, STATUS_OK);
               slot      = slot + 1'b1;
               do_handle = 1'b1;
            end
         end else begin
            do_handle = 1'b1;
         end
      end

      if (do_handle) begin
         go = 1'b1;
         if (mode_in == MODE_GAP) begin
            if (ws) begin
               go = 1'b0;
            end else if (cnt_in >= CNT_W'(MAX_ARGS)) begin
               err_in = 1'b1;
               go     = 1'b0;
            end else begin
               mode_in = MODE_TOKEN;
            end
         end
         if (go) begin
            if (char_in == CH_BSLASH) begin
               bsp_in = 1'b1;
            end else if (char_in == CH_QUOTE) begin
               mode_in = (mode_in == MODE_QUOTED) ? MODE_TOKEN : MODE_QUOTED;
            end else if (ws && mode_in == MODE_TOKEN) begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_END, '0, cnt_in, STATUS_OK);
               slot    = slot + 1'b1;
               cnt_in  = cnt_in + 1'b1;
               mode_in = MODE_GAP;
            end else begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_BYTE, char_in, cnt_in, STATUS_OK);
               slot = slot + 1'b1;
            end
         end
      end

      if (line_end) begin
         if (err_in) begin
            status = STATUS_TOO_MANY;
         end else begin
            if (bsp_in) begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_BYTE, CH_BSLASH, cnt_in, STATUS_OK);
               slot = slot + 1'b1;
            end
            if (mode_in == MODE_QUOTED) begin
               status = STATUS_UNTERM;
            end else if (mode_in == MODE_TOKEN) begin
               pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_END, '0, cnt_in, STATUS_OK);
               slot   = slot + 1'b1;
               cnt_in = cnt_in + 1'b1;
            end
         end
         pkt.item[slot[RES_IDX_W-1:0]] = make_item(KIND_DONE, '0, cnt_in, status);
         slot = slot + 1'b1;
         // start the next line clean
         mode_in = MODE_GAP;
         bsp_in  = 1'b0;
         cnt_in  = '0;
         err_in  = 1'b0;
      end
      pkt.n = slot;
   end

   assign q_push = accept && (pkt.n != '0);
   assign q_pkt  = pkt;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_GAP;
         bsp_ff  <= 1'b0;
         cnt_ff  <= '0;
         err_ff  <= 1'b0;
      end else if (accept) begin
         mode_ff <= mode_in;
         bsp_ff  <= bsp_in;
         cnt_ff  <= cnt_in;
         err_ff  <= err_in;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ARGS))
      else $error("token count beyond limit");

   a_line_reset: assert property (@(posedge clock) disable iff (reset)
      (accept && line_end) |=> (mode_ff == MODE_GAP && cnt_ff == '0 && !err_ff && !bsp_ff))
      else $error("scan state not cleared after line end");

endmodule

// File: hdl/clt_queue.sv
// ----------------------------------------------------------------------------
// clt_queue
// Short packet queue between the classifier and the result sequencer.
// ----------------------------------------------------------------------------
module clt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  clt_pkg::pkt_type     wr_pkt,
   input  logic                 rd_en,
   output clt_pkg::pkt_type     rd_pkt,
   output clt_pkg::qstat_type   stat
);
   import clt_pkg::*;

   pkt_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_wr, do_rd;

   assign stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_wr      = wr_en && !stat.full;
   assign do_rd      = rd_en && !stat.empty;
   assign rd_pkt     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_pkt;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_lost_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !stat.full)
      else $error("packet pushed into full queue");

endmodule

// File: hdl/clt_back.sv
// ----------------------------------------------------------------------------
// clt_back
// Result sequencer: presents the results of one packet, one per pop.
// ----------------------------------------------------------------------------
module clt_back (
   input  logic                              clock,
   input  logic                              reset,
   input  clt_pkg::qstat_type                q_stat,
   input  clt_pkg::pkt_type                  q_pkt,
   output logic                              q_pop,
   output logic                              empty,
   input  logic                              pop,
   output logic [1:0]                        rsp_kind,
   output logic [clt_pkg::CHAR_W-1:0]        rsp_token_byte,
   output logic [clt_pkg::TOKEN_IDX_W-1:0]   rsp_token_index,
   output logic [1:0]                        rsp_line_status,
   output logic [clt_pkg::ARG_COUNT_W-1:0]   rsp_arg_count,
   output logic                              rsp_last_result
);
   import clt_pkg::*;

   pkt_type                cur_ff, cur_in;
   logic [RES_IDX_W-1:0]   idx_ff, idx_in;
   logic                   busy_ff, busy_in;
   logic                   last;
   logic                   take_next;
   rsp_item_type           item;

   assign item      = cur_ff.item[idx_ff];
   assign last      = (RES_CNT_W'(idx_ff) == cur_ff.n - RES_CNT_W'(1));
   assign take_next = !busy_ff || (pop && last);
   assign q_pop     = take_next && !q_stat.empty;
   assign empty     = !busy_ff;

   always_comb begin
      cur_in  = cur_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      if (take_next) begin
         busy_in = !q_stat.empty;
         idx_in  = '0;
         if (q_pop) begin
            cur_in = q_pkt;
         end
      end else if (pop) begin
         // advance within the packet
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign rsp_kind        = item.kind;
   assign rsp_token_byte  = item.token_byte;
   assign rsp_token_index = item.token_index;
   assign rsp_line_status = item.line_status;
   assign rsp_arg_count   = item.arg_count;
   assign rsp_last_result = last;

   a_busy_pkt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cur_ff.n != '0 && RES_CNT_W'(idx_ff) < cur_ff.n))
      else $error("result index outside packet");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !pop) |=> (busy_ff && $stable(idx_ff)))
      else $error("result moved without pop");

endmodule

// File: hdl/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// command_line_tokenizer
// Splits a command line into tokens, one character per item.
// ----------------------------------------------------------------------------
// Path: an item's results go into the packet queue, then into the sequencer's
// packet register. Throughput: one item per cycle while the queue is not full
// and items cause at most one result; each result takes one pop.
// A four-entry packet queue between classifier and sequencer absorbs bursts.
// Reset is synchronous: it clears scan state, queue and output sequencer.
module command_line_tokenizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [clt_pkg::CHAR_W-1:0]        req_char_in,
   input  logic                              req_line_end,
   output logic                              empty,
   input  logic                              pop,
   output logic [1:0]                        rsp_kind,
   output logic [clt_pkg::CHAR_W-1:0]        rsp_token_byte,
   output logic [clt_pkg::TOKEN_IDX_W-1:0]   rsp_token_index,
   output logic [1:0]                        rsp_line_status,
   output logic [clt_pkg::ARG_COUNT_W-1:0]   rsp_arg_count,
   output logic                              rsp_last_result
);
   import clt_pkg::*;

   logic        q_push;
   logic        q_pop;
   pkt_type     wr_pkt;
   pkt_type     rd_pkt;
   qstat_type   q_stat;

   assign full = q_stat.full;

   clt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_stat.full),
      .char_in  (req_char_in),
      .line_end (req_line_end),
      .q_push   (q_push),
      .q_pkt    (wr_pkt)
   );

   clt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_pkt (wr_pkt),
      .rd_en  (q_pop),
      .rd_pkt (rd_pkt),
      .stat   (q_stat)
   );

   clt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .q_pkt           (rd_pkt),
      .q_pop           (q_pop),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_line_status (rsp_line_status),
      .rsp_arg_count   (rsp_arg_count),
      .rsp_last_result (rsp_last_result)
   );

endmodule

// File: tb/sv/command_line_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// command_line_tokenizer_tb
// Feeds command lines one character per item and checks every token byte,
// token end and line status against a cycle-free model of the tokenizer.
// Covers quoting, escaped quotes, stray backslashes, argument overflow,
// random lines and noise, under random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module command_line_tokenizer_tb;
   import clt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;

   typedef enum logic [1:0] {
      SCAN_GAP    = 2'd0,
      SCAN_WORD   = 2'd1,
      SCAN_QUOTED = 2'd2
   } scan_type;

   typedef struct packed {
      kind_type                 kind;
      logic [CHAR_W-1:0]        tbyte;
      logic [TOKEN_IDX_W-1:0]   tidx;
      status_type               status;
      logic [ARG_COUNT_W-1:0]   count;
      logic                     last_res;
   } token_result_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      push = 1'b0;
   logic                      full;
   logic [CHAR_W-1:0]         req_char_in = '0;
   logic                      req_line_end = 1'b0;
   logic                      empty;
   logic                      pop = 1'b0;
   logic [1:0]                rsp_kind;
   logic [CHAR_W-1:0]         rsp_token_byte;
   logic [TOKEN_IDX_W-1:0]    rsp_token_index;
   logic [1:0]                rsp_line_status;
   logic [ARG_COUNT_W-1:0]    rsp_arg_count;
   logic                      rsp_last_result;

   // tokenizer model state
   scan_type                  scan = SCAN_GAP;
   bit                        bs_wait = 1'b0;
   logic [ARG_COUNT_W-1:0]    tok_done = '0;
   bit                        overflow = 1'b0;

   token_result_type          step_res[$];
   token_result_type          results_due[$];
   logic [CHAR_W-1:0]         line_buf[$];

   int                        errors = 0;
   int                        items_sent = 0;
   int                        cycle_count = 0;
   int                        hold_cycles = 0;
   bit                        no_idle = 1'b0;

   command_line_tokenizer i_dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_char_in     (req_char_in),
      .req_line_end    (req_line_end),
      .empty           (empty),
      .pop             (pop),
      .rsp_kind        (rsp_kind),
      .rsp_token_byte  (rsp_token_byte),
      .rsp_token_index (rsp_token_index),
      .rsp_line_status (rsp_line_status),
      .rsp_arg_count   (rsp_arg_count),
      .rsp_last_result (rsp_last_result)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // tokenizer model
   // ------------------------------------------------------------------
   function void put_res(kind_type k, logic [CHAR_W-1:0] b, status_type s);
      token_result_type r;
      r.kind     = k;
      r.tbyte    = b;
      r.tidx     = (k == KIND_DONE) ? '0 : tok_done[TOKEN_IDX_W-1:0];
      r.status   = s;
      r.count    = (k == KIND_DONE) ? tok_done : '0;
      r.last_res = 1'b0;
      step_res.push_back(r);
   endfunction

   function void scan_char(logic [CHAR_W-1:0] c);
      bit ws;
      ws = (c == CH_SPACE) || (c == CH_TAB);
      if (scan == SCAN_GAP) begin
         if (ws) return;
         // a new token with the table already full kills the line
         if (tok_done >= MAX_ARGS) begin
            overflow = 1'b1;
            return;
         end
         scan = SCAN_WORD;
      end
      if (c == CH_BSLASH) begin
         bs_wait = 1'b1;
      end else if (c == CH_QUOTE) begin
         scan = (scan == SCAN_QUOTED) ? SCAN_WORD : SCAN_QUOTED;
      end else if (ws && scan == SCAN_WORD) begin
         put_res(KIND_END, '0, STATUS_OK);
         tok_done++;
         scan = SCAN_GAP;
      end else begin
         put_res(KIND_BYTE, c, STATUS_OK);
      end
   endfunction

   function void tokenize_char(logic [CHAR_W-1:0] c, bit le);
      status_type st;
      step_res.delete();
      if (!overflow) begin
         if (bs_wait) begin
            bs_wait = 1'b0;
            if (c == CH_QUOTE) begin
               put_res(KIND_BYTE, CH_QUOTE, STATUS_OK);
            end else begin
               put_res(KIND_BYTE, CH_BSLASH, STATUS_OK);
               scan_char(c);
            end
         end else begin
            scan_char(c);
         end
      end
      if (le) begin
         st = STATUS_OK;
         if (overflow) begin
            st = STATUS_TOO_MANY;
         end else begin
            if (bs_wait) begin
               put_res(KIND_BYTE, CH_BSLASH, STATUS_OK);
               bs_wait = 1'b0;
            end
            if (scan == SCAN_QUOTED) begin
               st = STATUS_UNTERM;
            end else if (scan == SCAN_WORD) begin
               put_res(KIND_END, '0, STATUS_OK);
               tok_done++;
            end
         end
         put_res(KIND_DONE, '0, st);
         scan     = SCAN_GAP;
         bs_wait  = 1'b0;
         tok_done = '0;
         overflow = 1'b0;
      end
      if (step_res.size() > 0) step_res[step_res.size()-1].last_res = 1'b1;
      foreach (step_res[i]) results_due.push_back(step_res[i]);
   endfunction

   // ------------------------------------------------------------------
   // driving and checking
   // ------------------------------------------------------------------
   function int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_item(logic [CHAR_W-1:0] c, bit le);
      int unsigned gap;
      gap = idle_len();
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push         <= 1'b1;
      req_char_in  <= c;
      req_line_end <= le;
      do @(posedge clock); while (full);
      items_sent++;
      tokenize_char(c, le);
   endtask

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   task check_result();
      token_result_type e;
      if (results_due.size() == 0) begin
         $error("unexpected result: kind %0d byte %0h index %0d status %0d count %0d",
                rsp_kind, rsp_token_byte, rsp_token_index, rsp_line_status,
                rsp_arg_count);
         errors++;
      end else begin
         e = results_due.pop_front();
         check_field("kind", 8'(e.kind), 8'(rsp_kind));
         check_field("token_byte", e.tbyte, rsp_token_byte);
         check_field("token_index", 8'(e.tidx), 8'(rsp_token_index));
         check_field("line_status", 8'(e.status), 8'(rsp_line_status));
         check_field("arg_count", 8'(e.count), 8'(rsp_arg_count));
         check_field("last_result", 8'(e.last_res), 8'(rsp_last_result));
      end
   endtask

   initial begin : rsp_side
      int unsigned stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && pop && !empty) check_result();
         // long hold-off first, then ordinary random stalls
         if (hold_cycles > 0) begin
            hold_cycles--;
            pop <= 1'b0;
         end else if (stall > 0) begin
            stall--;
            pop <= 1'b0;
         end else begin
            stall = idle_len();
            if (stall != 0) begin
               stall--;
               pop <= 1'b0;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   task wait_drain();
      push <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // line building
   // ------------------------------------------------------------------
   function logic [CHAR_W-1:0] plain_char();
      logic [CHAR_W-1:0] c;
      do c = CHAR_W'($urandom_range(0, 255));
      while (c == CH_SPACE || c == CH_TAB || c == CH_QUOTE || c == CH_BSLASH);
      return c;
   endfunction

   function void put_str(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   function void add_gap();
      repeat ($urandom_range(1, 2))
         line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
   endfunction

   function void add_word();
      int unsigned pick;
      repeat ($urandom_range(1, 4)) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(plain_char());
         end else if (pick < 7) begin
            // quoted span, whitespace and escaped quotes inside
            line_buf.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 3)) begin
               case ($urandom_range(0, 3))
                  0: line_buf.push_back(CH_SPACE);
                  1: line_buf.push_back(CH_TAB);
                  2: begin
                     line_buf.push_back(CH_BSLASH);
                     line_buf.push_back(CH_QUOTE);
                  end
                  default: line_buf.push_back(plain_char());
               endcase
            end
            line_buf.push_back(CH_QUOTE);
         end else if (pick == 7) begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(CH_QUOTE);
         end else if (pick == 8) begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(plain_char());
         end else begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(CH_BSLASH);
         end
      end
   endfunction

   function void build_line();
      int unsigned words;
      if ($urandom_range(0, 3) == 0) add_gap();
      words = $urandom_range(0, 5);
      for (int i = 0; i < words; i++) begin
         if (i > 0) add_gap();
         add_word();
      end
      if ($urandom_range(0, 4) == 0) add_gap();
      case ($urandom_range(0, 19))
         0, 1: begin
            line_buf.push_back(CH_QUOTE);
            repeat ($urandom_range(0, 2)) line_buf.push_back(plain_char());
         end
         2: line_buf.push_back(CH_BSLASH);
         default: ;
      endcase
      if (line_buf.size() == 0) line_buf.push_back(CH_SPACE);
   endfunction

   task send_buf();
      for (int i = 0; i < line_buf.size(); i++)
         send_item(line_buf[i], i == line_buf.size() - 1);
      line_buf.delete();
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task test_directed();
      put_str("a");               send_buf();
      put_str(" \"\"");           send_buf();   // empty quoted token
      put_str("\"a\\\"");         send_buf();   // open quote, escaped quote inside
      put_str("\\");              send_buf();   // backslash alone at line end
      put_str("x\\y\t");          send_buf();   // backslash before ordinary char
      line_buf.push_back(8'h00);
      line_buf.push_back(8'hFF);  send_buf();
      put_str(" ");               send_buf();   // whitespace only
      put_str("\\\"q");           send_buf();   // escaped quote opens a token
      put_str("b\\ c");           send_buf();   // backslash before a separator
   endtask

   task test_arg_limit();
      int unsigned n;
      for (int k = 0; k < 3; k++) begin
         n = (k == 0) ? 16 : (k == 1) ? 17 : 15 + $urandom_range(0, 3);
         for (int i = 0; i < n; i++) begin
            if (i > 0) add_gap();
            line_buf.push_back(plain_char());
         end
         // whitespace after the last allowed token is fine, more words are not
         if (k == 0) add_gap();
         else if (n > 16) begin
            add_gap();
            add_word();
         end
         send_buf();
      end
   endtask

   task test_random_lines(int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         no_idle = ($urandom_range(0, 4) == 0);
         build_line();
         send_buf();
      end
      no_idle = 1'b0;
   endtask

   task test_backpressure();
      int start;
      start = items_sent;
      hold_cycles = 150;
      while (items_sent - start < 30) begin
         build_line();
         send_buf();
      end
   endtask

   task test_noise();
      repeat (24) send_item(CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
      send_item(plain_char(), 1'b1);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      wait_drain();
      test_arg_limit();
      wait_drain();
      test_random_lines(30);
      wait_drain();
      test_backpressure();
      wait_drain();
      test_noise();
      wait_drain();
      test_random_lines(20);
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && results_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
